// File: hdl/f2u8rq_pkg.sv
// f2u8rq_pkg: shared types, register indexes and a helper function for the requantizer
// no dependencies; used by the adder, the multiplier and the top level

package f2u8rq_pkg;

    // single-precision word split into its fields
    typedef struct packed {
        logic        sign;
        logic [7:0]  exp;
        logic [22:0] frac;
    } fp32_t;

    localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
    localparam fp32_t      FP_QNAN      = '{sign: 1'b0, exp: 8'hFF, frac: 23'h400000};

    // configuration register indexes
    localparam logic [2:0] CFG_SRC_SCALE = 3'd0;
    localparam logic [2:0] CFG_DST_SCALE = 3'd1;
    localparam logic [2:0] CFG_SRC_ZERO  = 3'd2;
    localparam logic [2:0] CFG_DST_ZERO  = 3'd3;
    localparam logic [2:0] CFG_BETA      = 3'd4;

    // leading zero count of a 48-bit word, 48 when all zero
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

endpackage

// File: hdl/f2u8rq_fadd.sv
// f2u8rq_fadd: four-stage single-precision adder, round to nearest even, subnormals kept
// depends on f2u8rq_pkg

module f2u8rq_fadd (
    input  logic                aclk,
    input  logic                en,
    input  f2u8rq_pkg::fp32_t   a,
    input  f2u8rq_pkg::fp32_t   b,
    output f2u8rq_pkg::fp32_t   y
);

    // stage 1: unpack, order by magnitude
    logic              a_nan, b_nan, a_inf, b_inf, swap, sub_op;
    f2u8rq_pkg::fp32_t big, sml;
    logic [7:0]        big_e, sml_e;

    logic        s1_sign_reg, s1_sub_reg, s1_nan_reg, s1_inf_reg;
    logic [7:0]  s1_e_reg, s1_diff_reg;
    logic [23:0] s1_bm_reg, s1_sm_reg;

    always_comb begin
        a_nan  = (a.exp == f2u8rq_pkg::EXP_ALL_ONES) && (a.frac != '0);
        b_nan  = (b.exp == f2u8rq_pkg::EXP_ALL_ONES) && (b.frac != '0);
        a_inf  = (a.exp == f2u8rq_pkg::EXP_ALL_ONES) && (a.frac == '0);
        b_inf  = (b.exp == f2u8rq_pkg::EXP_ALL_ONES) && (b.frac == '0);
        swap   = {b.exp, b.frac} > {a.exp, a.frac};
        big    = swap ? b : a;
        sml    = swap ? a : b;
        big_e  = (big.exp == '0) ? 8'd1 : big.exp;
        sml_e  = (sml.exp == '0) ? 8'd1 : sml.exp;
        sub_op = a.sign ^ b.sign;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_sign_reg <= big.sign;
            s1_sub_reg  <= sub_op;
            s1_nan_reg  <= a_nan | b_nan | (a_inf & b_inf & sub_op);
            s1_inf_reg  <= a_inf | b_inf;
            s1_e_reg    <= big_e;
            s1_diff_reg <= big_e - sml_e;
            s1_bm_reg   <= {big.exp != '0, big.frac};
            s1_sm_reg   <= {sml.exp != '0, sml.frac};
        end
    end

    // stage 2: align the smaller operand with sticky, add or subtract
    logic [26:0] bm_x, sm_x, al, lost_mask;
    logic [27:0] sum_next;

    logic        s2_sign_reg, s2_nan_reg, s2_inf_reg;
    logic [7:0]  s2_e_reg;
    logic [27:0] s2_sum_reg;

    always_comb begin
        bm_x      = {s1_bm_reg, 3'b000};
        sm_x      = {s1_sm_reg, 3'b000};
        lost_mask = ~(27'h7FFFFFF << s1_diff_reg[4:0]);
        if (s1_diff_reg >= 8'd27) begin
            al = {26'b0, |s1_sm_reg};
        end else begin
            al    = sm_x >> s1_diff_reg[4:0];
            al[0] = al[0] | (|(sm_x & lost_mask));
        end
        if (s1_sub_reg) begin
            sum_next = {1'b0, bm_x} - {1'b0, al};
        end else begin
            sum_next = {1'b0, bm_x} + {1'b0, al};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_sign_reg <= s1_sign_reg;
            s2_nan_reg  <= s1_nan_reg;
            s2_inf_reg  <= s1_inf_reg;
            s2_e_reg    <= s1_e_reg;
            s2_sum_reg  <= sum_next;
        end
    end

    // stage 3: normalise, never below the smallest exponent
    logic [5:0]  lz, sh;
    logic [9:0]  e_m1, e_next;
    logic [26:0] norm_next;

    logic        s3_sign_reg, s3_nan_reg, s3_inf_reg;
    logic [9:0]  s3_e_reg;
    logic [26:0] s3_norm_reg;

    always_comb begin
        lz   = f2u8rq_pkg::lzc48({s2_sum_reg[26:0], 21'b0});
        e_m1 = {2'b0, s2_e_reg} - 10'd1;
        sh   = '0;
        if (s2_sum_reg[27]) begin
            norm_next = {s2_sum_reg[27:2], s2_sum_reg[1] | s2_sum_reg[0]};
            e_next    = {2'b0, s2_e_reg} + 10'd1;
        end else begin
            sh        = ({4'b0, lz} < e_m1) ? lz : e_m1[5:0];
            norm_next = s2_sum_reg[26:0] << sh;
            e_next    = {2'b0, s2_e_reg} - {4'b0, sh};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_sign_reg <= s2_sign_reg;
            s3_nan_reg  <= s2_nan_reg;
            s3_inf_reg  <= s2_inf_reg;
            s3_e_reg    <= e_next;
            s3_norm_reg <= norm_next;
        end
    end

    // stage 4: round to nearest even and pack
    logic [23:0]       mant, mf;
    logic              rnd_up;
    logic [24:0]       mr;
    logic [9:0]        ef;
    f2u8rq_pkg::fp32_t y_next, y_reg;

    always_comb begin
        mant   = s3_norm_reg[26:3];
        rnd_up = s3_norm_reg[2] & ((|s3_norm_reg[1:0]) | mant[0]);
        mr     = {1'b0, mant} + {24'b0, rnd_up};
        if (mr[24]) begin
            mf = mr[24:1];
            ef = s3_e_reg + 10'd1;
        end else begin
            mf = mr[23:0];
            ef = s3_e_reg;
        end
        if (s3_nan_reg) begin
            y_next = f2u8rq_pkg::FP_QNAN;
        end else if (s3_inf_reg || (ef >= 10'd255)) begin
            y_next = '{sign: s3_sign_reg, exp: f2u8rq_pkg::EXP_ALL_ONES, frac: 23'b0};
        end else begin
            y_next = '{sign: s3_sign_reg, exp: (mf[23] ? ef[7:0] : 8'h00), frac: mf[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// File: hdl/f2u8rq_fmul.sv
// f2u8rq_fmul: four-stage single-precision multiplier, round to nearest even, subnormals kept
// depends on f2u8rq_pkg

module f2u8rq_fmul (
    input  logic                aclk,
    input  logic                en,
    input  f2u8rq_pkg::fp32_t   a,
    input  f2u8rq_pkg::fp32_t   b,
    output f2u8rq_pkg::fp32_t   y
);

    // stage 1: unpack and multiply significands
    logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0]        ae, be;
    logic [23:0]       am, bm;

    logic               s1_sign_reg, s1_nan_reg, s1_inf_reg;
    logic signed [10:0] s1_e_reg;
    logic [47:0]        s1_prod_reg;

    always_comb begin
        a_nan  = (a.exp == f2u8rq_pkg::EXP_ALL_ONES) && (a.frac != '0);
        b_nan  = (b.exp == f2u8rq_pkg::EXP_ALL_ONES) && (b.frac != '0);
        a_inf  = (a.exp == f2u8rq_pkg::EXP_ALL_ONES) && (a.frac == '0);
        b_inf  = (b.exp == f2u8rq_pkg::EXP_ALL_ONES) && (b.frac == '0);
        a_zero = (a.exp == '0) && (a.frac == '0);
        b_zero = (b.exp == '0) && (b.frac == '0);
        ae     = (a.exp == '0) ? 8'd1 : a.exp;
        be     = (b.exp == '0) ? 8'd1 : b.exp;
        am     = {a.exp != '0, a.frac};
        bm     = {b.exp != '0, b.frac};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_sign_reg <= a.sign ^ b.sign;
            s1_nan_reg  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
            s1_inf_reg  <= a_inf | b_inf;
            s1_e_reg    <= $signed({3'b0, ae}) + $signed({3'b0, be}) - 11'sd127;
            s1_prod_reg <= am * bm;
        end
    end

    // stage 2: leading zeros and shift plan (left to normalise or right into subnormal)
    logic [5:0]         lz;
    logic signed [10:0] lz_s, neg_e;
    logic               left_next;
    logic [6:0]         amt_next;
    logic signed [10:0] e_next;

    logic               s2_sign_reg, s2_nan_reg, s2_inf_reg, s2_left_reg;
    logic [6:0]         s2_amt_reg;
    logic signed [10:0] s2_e_reg;
    logic [47:0]        s2_prod_reg;

    always_comb begin
        lz    = f2u8rq_pkg::lzc48(s1_prod_reg);
        lz_s  = $signed({5'b0, lz});
        neg_e = -s1_e_reg;
        if (s1_e_reg >= lz_s) begin
            left_next = 1'b1;
            amt_next  = {1'b0, lz};
            e_next    = s1_e_reg + 11'sd1 - lz_s;
        end else if (s1_e_reg >= 11'sd0) begin
            left_next = 1'b1;
            amt_next  = s1_e_reg[6:0];
            e_next    = 11'sd1;
        end else begin
            left_next = 1'b0;
            amt_next  = neg_e[6:0];
            e_next    = 11'sd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_sign_reg <= s1_sign_reg;
            s2_nan_reg  <= s1_nan_reg;
            s2_inf_reg  <= s1_inf_reg;
            s2_left_reg <= left_next;
            s2_amt_reg  <= amt_next;
            s2_e_reg    <= e_next;
            s2_prod_reg <= s1_prod_reg;
        end
    end

    // stage 3: apply the shift, keep a sticky bit for a right shift
    logic [47:0] pn_next;
    logic        st_next;

    logic               s3_sign_reg, s3_nan_reg, s3_inf_reg, s3_st_reg;
    logic signed [10:0] s3_e_reg;
    logic [47:0]        s3_pn_reg;

    always_comb begin
        if (s2_left_reg) begin
            pn_next = s2_prod_reg << s2_amt_reg[5:0];
            st_next = 1'b0;
        end else if (s2_amt_reg >= 7'd48) begin
            pn_next = '0;
            st_next = |s2_prod_reg;
        end else begin
            pn_next = s2_prod_reg >> s2_amt_reg[5:0];
            st_next = |(s2_prod_reg & ~(48'hFFFF_FFFF_FFFF << s2_amt_reg[5:0]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_sign_reg <= s2_sign_reg;
            s3_nan_reg  <= s2_nan_reg;
            s3_inf_reg  <= s2_inf_reg;
            s3_st_reg   <= st_next;
            s3_e_reg    <= s2_e_reg;
            s3_pn_reg   <= pn_next;
        end
    end

    // stage 4: round to nearest even and pack
    logic [23:0]        mant, mf;
    logic               rnd_up;
    logic [24:0]        mr;
    logic signed [10:0] ef;
    f2u8rq_pkg::fp32_t  y_next, y_reg;

    always_comb begin
        mant   = s3_pn_reg[47:24];
        rnd_up = s3_pn_reg[23] & ((|s3_pn_reg[22:0]) | s3_st_reg | mant[0]);
        mr     = {1'b0, mant} + {24'b0, rnd_up};
        if (mr[24]) begin
            mf = mr[24:1];
            ef = s3_e_reg + 11'sd1;
        end else begin
            mf = mr[23:0];
            ef = s3_e_reg;
        end
        if (s3_nan_reg) begin
            y_next = f2u8rq_pkg::FP_QNAN;
        end else if (s3_inf_reg || (ef >= 11'sd255)) begin
            y_next = '{sign: s3_sign_reg, exp: f2u8rq_pkg::EXP_ALL_ONES, frac: 23'b0};
        end else begin
            y_next = '{sign: s3_sign_reg, exp: (mf[23] ? ef[7:0] : 8'h00), frac: mf[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// File: hdl/float_to_u8_requantizer.sv
// float_to_u8_requantizer: top level, affine requantisation of single-precision values to bytes
// depends on f2u8rq_pkg, f2u8rq_fadd, f2u8rq_fmul
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata[31:0] in_value, [39:32] old_byte; s_tlast last_in
//  m_        out  m_tvalid/m_tready  m_tdata[7:0] q_byte; m_tlast last_out
//  cfg_      in   cfg_we             cfg_index register, cfg_wdata value
//
//  one beat per cycle in and out while no result waits on m_tready; a beat passes
//  through 21 register stages: three entry stages, four adder/multiplier units of four
//  stages each, round, clamp
//  the whole pipeline holds while a result waits on m_tready; s_tready follows that hold
//  zero points are converted by a three-stage side pipeline after each write, source to float
//  reset is synchronous, active low, clears valid bits and sets config registers to their defaults

module float_to_u8_requantizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [31:0] in_value, [39:32] old_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] q_byte
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int NSTG = 20;   // stages ahead of the output register

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0] src_scale_reg, dst_scale_reg, src_zero_reg, dst_zero_reg, beta_reg;
    logic        beta_nz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_scale_reg <= 32'h3F80_0000;
            dst_scale_reg <= 32'h3F80_0000;
            src_zero_reg  <= '0;
            dst_zero_reg  <= '0;
            beta_reg      <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                f2u8rq_pkg::CFG_SRC_SCALE: src_scale_reg <= cfg_wdata;
                f2u8rq_pkg::CFG_DST_SCALE: dst_scale_reg <= cfg_wdata;
                f2u8rq_pkg::CFG_SRC_ZERO:  src_zero_reg  <= cfg_wdata;
                f2u8rq_pkg::CFG_DST_ZERO:  dst_zero_reg  <= cfg_wdata;
                f2u8rq_pkg::CFG_BETA:      beta_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // plus and minus zero both switch the beta term off
    assign beta_nz = |beta_reg[30:0];

    // ------------------------------------------------------------------
    // zero point conversion, lane 0 source, lane 1 destination
    // free running; the value settles through the zc1, zc2 and szf_reg/dz_reg registers after a write
    // ------------------------------------------------------------------
    logic [31:0] zp_in [2];
    logic [31:0] zp_mag_next [2];
    logic [5:0]  zp_lz [2];

    logic        zc1_neg_reg [2];
    logic [31:0] zc1_mag_reg [2];
    logic [4:0]  zc1_p_reg [2];

    logic [3:0]  zc_k [2];
    logic [32:0] zc_half [2];
    logic [32:0] zc_m_next [2];

    logic        zc2_neg_reg [2];
    logic [32:0] zc2_m_reg [2];
    logic [4:0]  zc2_p_reg [2];

    assign zp_in[0] = src_zero_reg;
    assign zp_in[1] = dst_zero_reg;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            zp_mag_next[i] = zp_in[i][31] ? (32'd0 - zp_in[i]) : zp_in[i];
            zp_lz[i]       = f2u8rq_pkg::lzc48({zp_mag_next[i], 16'b0});
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 2; i++) begin
            zc1_neg_reg[i] <= zp_in[i][31];
            zc1_mag_reg[i] <= zp_mag_next[i];
            zc1_p_reg[i]   <= 5'(6'd31 - zp_lz[i]);
        end
    end

    // round the magnitude to 24 significant bits, ties to even
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            zc_k[i]    = (zc1_p_reg[i] > 5'd23) ? 4'(zc1_p_reg[i] - 5'd23) : 4'd0;
            zc_half[i] = '0;
            if (zc_k[i] == 4'd0) begin
                zc_m_next[i] = {1'b0, zc1_mag_reg[i]};
            end else begin
                zc_half[i]   = 33'd1 << (zc_k[i] - 4'd1);
                zc_m_next[i] = ({1'b0, zc1_mag_reg[i]} + zc_half[i] - 33'd1
                                + {32'b0, zc1_mag_reg[i][zc_k[i]]})
                               & (~33'd0 << zc_k[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 2; i++) begin
            zc2_neg_reg[i] <= zc1_neg_reg[i];
            zc2_m_reg[i]   <= zc_m_next[i];
            zc2_p_reg[i]   <= zc1_p_reg[i];
        end
    end

    // pack the source zero point as a float, keep the destination one as an integer
    logic [5:0]        szp;
    logic [32:0]       szm;
    f2u8rq_pkg::fp32_t szf_next, szf_reg;
    logic [33:0]       dzm;
    logic signed [33:0] dz_reg;

    always_comb begin
        szp = zc2_m_reg[0][6'({1'b0, zc2_p_reg[0]} + 6'd1)] ?
              ({1'b0, zc2_p_reg[0]} + 6'd1) : {1'b0, zc2_p_reg[0]};
        if (szp >= 6'd23) begin
            szm = zc2_m_reg[0] >> (szp - 6'd23);
        end else begin
            szm = zc2_m_reg[0] << (6'd23 - szp);
        end
        if (zc2_m_reg[0] == '0) begin
            szf_next = '0;
        end else begin
            szf_next = '{sign: zc2_neg_reg[0], exp: 8'(8'd127 + {2'b0, szp}),
                         frac: szm[22:0]};
        end
        dzm = {1'b0, zc2_m_reg[1]};
    end

    always_ff @(posedge aclk) begin
        szf_reg <= szf_next;
        dz_reg  <= zc2_neg_reg[1] ? $signed(34'd0 - dzm) : $signed(dzm);
    end

    // ------------------------------------------------------------------
    // pipeline control: every stage moves together unless the output waits
    // ------------------------------------------------------------------
    logic            adv;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] last_reg;
    logic            m_tvalid_reg, m_tlast_reg;
    logic [7:0]      m_tdata_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= {vld_reg[NSTG-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            last_reg <= {last_reg[NSTG-2:0], s_tlast};
        end
    end

    // ------------------------------------------------------------------
    // entry stages: capture, old byte to float, wait for the zero point
    // ------------------------------------------------------------------
    logic [31:0]       x0_reg;
    logic [7:0]        old0_reg;
    f2u8rq_pkg::fp32_t x1_reg, x2_reg;
    f2u8rq_pkg::fp32_t oldf_next, oldf1_reg, oldf2_reg;
    logic [5:0]        old_lz;
    logic [7:0]        old_norm;

    always_comb begin
        old_lz   = f2u8rq_pkg::lzc48({old0_reg, 40'b0});
        old_norm = old0_reg << old_lz[2:0];
        if (old0_reg == '0) begin
            oldf_next = '0;
        end else begin
            oldf_next = '{sign: 1'b0, exp: 8'(8'd134 - {2'b0, old_lz}),
                          frac: {old_norm[6:0], 16'b0}};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x0_reg    <= s_tdata[31:0];
            old0_reg  <= s_tdata[39:32];
            x1_reg    <= f2u8rq_pkg::fp32_t'(x0_reg);
            oldf1_reg <= oldf_next;
            x2_reg    <= x1_reg;
            oldf2_reg <= oldf1_reg;
        end
    end

    // ------------------------------------------------------------------
    // arithmetic chain
    // ------------------------------------------------------------------
    f2u8rq_pkg::fp32_t szf_neg, diff_y, scl_y, acc_y, sum_y, blend, out_y;
    f2u8rq_pkg::fp32_t oldf_d_reg [4];
    f2u8rq_pkg::fp32_t byp_d_reg [4];

    assign szf_neg = '{sign: ~szf_reg.sign, exp: szf_reg.exp, frac: szf_reg.frac};

    // x - src_zero
    f2u8rq_fadd u_sub (
        .aclk (aclk),
        .en   (adv),
        .a    (x2_reg),
        .b    (szf_neg),
        .y    (diff_y)
    );

    // old byte waits beside the subtraction
    always_ff @(posedge aclk) begin
        if (adv) begin
            oldf_d_reg[0] <= oldf2_reg;
            for (int i = 1; i < 4; i++) begin
                oldf_d_reg[i] <= oldf_d_reg[i-1];
            end
        end
    end

    // times src_scale
    f2u8rq_fmul u_scl (
        .aclk (aclk),
        .en   (adv),
        .a    (diff_y),
        .b    (f2u8rq_pkg::fp32_t'(src_scale_reg)),
        .y    (scl_y)
    );

    // beta times old byte, alongside
    f2u8rq_fmul u_beta (
        .aclk (aclk),
        .en   (adv),
        .a    (f2u8rq_pkg::fp32_t'(beta_reg)),
        .b    (oldf_d_reg[3]),
        .y    (acc_y)
    );

    // accumulate; the copy without the beta term waits beside for when beta is off
    f2u8rq_fadd u_acc (
        .aclk (aclk),
        .en   (adv),
        .a    (scl_y),
        .b    (acc_y),
        .y    (sum_y)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            byp_d_reg[0] <= scl_y;
            for (int i = 1; i < 4; i++) begin
                byp_d_reg[i] <= byp_d_reg[i-1];
            end
        end
    end

    assign blend = beta_nz ? sum_y : byp_d_reg[3];

    // times dst_scale
    f2u8rq_fmul u_dst (
        .aclk (aclk),
        .en   (adv),
        .a    (blend),
        .b    (f2u8rq_pkg::fp32_t'(dst_scale_reg)),
        .y    (out_y)
    );

    // ------------------------------------------------------------------
    // round to integer, ties to even; huge values and infinities saturate
    // to a magnitude well outside anything the zero point can pull back
    // ------------------------------------------------------------------
    logic [23:0]        rt_m, rt_int;
    logic [7:0]         rt_e, rt_sh;
    logic [4:0]         rt_shc;
    logic [49:0]        rt_w;
    logic               rt_nan, rt_up;
    logic [34:0]        rt_mag;
    logic signed [35:0] r_next, r_reg;
    logic               rnan_reg;

    always_comb begin
        rt_m   = {out_y.exp != '0, out_y.frac};
        rt_e   = (out_y.exp == '0) ? 8'd1 : out_y.exp;
        rt_nan = (out_y.exp == f2u8rq_pkg::EXP_ALL_ONES) && (out_y.frac != '0);
        rt_sh  = 8'd150 - rt_e;
        rt_shc = (rt_sh > 8'd26) ? 5'd26 : rt_sh[4:0];
        rt_w   = {rt_m, 26'b0} >> rt_shc;
        rt_int = rt_w[49:26];
        rt_up  = rt_w[25] & ((|rt_w[24:0]) | rt_int[0]);
        if (rt_e >= 8'd160) begin
            rt_mag = 35'h4_0000_0000;
        end else if (rt_e >= 8'd150) begin
            rt_mag = {11'b0, rt_m} << (rt_e - 8'd150);
        end else begin
            rt_mag = {11'b0, rt_int} + {34'b0, rt_up};
        end
        r_next = out_y.sign ? $signed(36'd0 - {1'b0, rt_mag}) : $signed({1'b0, rt_mag});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_reg    <= r_next;
            rnan_reg <= rt_nan;
        end
    end

    // ------------------------------------------------------------------
    // add destination zero point and clamp into the output register
    // ------------------------------------------------------------------
    logic signed [35:0] fin_sum;
    logic [7:0]         q_next;

    always_comb begin
        fin_sum = r_reg + {{2{dz_reg[33]}}, dz_reg};
        if (rnan_reg || (fin_sum <= 36'sd0)) begin
            q_next = 8'd0;
        end else if (fin_sum >= 36'sd255) begin
            q_next = 8'd255;
        end else begin
            q_next = fin_sum[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= q_next;
            m_tlast_reg <= last_reg[NSTG-1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: hdl/f2u8rq_checker.sv
// f2u8rq_checker: port-level assertions on the requantizer, attached by bind
// depends on float_to_u8_requantizer ports only

module f2u8rq_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // no result beat straight out of reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("held result beat changed");

    // a waiting result stalls the input side
    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result waits");

    // with nothing waiting the input side is open
    a_open_in: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

bind float_to_u8_requantizer f2u8rq_checker u_f2u8rq_checker (.*);
